[sv/mdf_pkg.sv]
// ----------------------------------------------------------------------------
// mdf_pkg: shared types and constants for the mode deviation flagger
// Sizes, field widths, result kinds and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mdf_pkg;

    localparam int MAX_SAMPLES  = 32;
    localparam int SPEED_LEVELS = 256;

    localparam int SPEED_W = 8;
    localparam int OCC_W   = 6;
    localparam int HIST_AW = $clog2(SPEED_LEVELS);
    localparam int SA_W    = $clog2(MAX_SAMPLES);
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);

    localparam logic [SPEED_W-1:0] LIMIT_RESET = 8'd10;

    localparam logic KIND_MODE = 1'b0;
    localparam logic KIND_DEV  = 1'b1;

    typedef struct packed {
        logic load;        // word accepted this cycle
        logic scan_clr;    // restart histogram scan
        logic scan_rd;     // read histogram at scan address, advance
        logic mode_load;   // mode result into pending slot
        logic rp_clr;      // replay index to zero
        logic rp_rd;       // read sample store at replay index
        logic rp_adv;      // replay index + 1
        logic push_dev;    // pending to output, deviant sample to pending
        logic push_final;  // pending to output as final word, clear the set
    } mdf_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic rp_done;
        logic dev_hit;
        logic out_free;
    } mdf_sts_t;

    function automatic logic [HIST_AW-1:0] sat_speed(input logic [SPEED_W-1:0] s);
        if (int'(s) >= SPEED_LEVELS) begin
            return HIST_AW'(SPEED_LEVELS - 1);
        end
        return HIST_AW'(s);
    endfunction

endpackage

[sv/mdf_ctrl.sv]
// ----------------------------------------------------------------------------
// mdf_ctrl: sequencing controller
// Load, histogram scan, ordered replay of stored samples, final word.
// ----------------------------------------------------------------------------
module mdf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    output logic              s_ready,
    input  mdf_pkg::mdf_sts_t sts,
    output mdf_pkg::mdf_cmd_t cmd
);
    import mdf_pkg::*;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_FLUSH = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SEND  = 3'd3;
    localparam logic [2:0] ST_MODE  = 3'd4;
    localparam logic [2:0] ST_RD    = 3'd5;
    localparam logic [2:0] ST_CHK   = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_LOAD);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                cmd.load = s_valid;
                if (s_valid && s_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // last histogram write lands here
                cmd.scan_clr = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                state_next = ST_MODE;
            end
            ST_MODE: begin
                cmd.mode_load = 1'b1;
                cmd.rp_clr    = 1'b1;
                state_next    = ST_RD;
            end
            ST_RD: begin
                if (sts.rp_done) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.rp_rd  = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (!sts.dev_hit) begin
                    cmd.rp_adv = 1'b1;
                    state_next = ST_RD;
                end else if (sts.out_free) begin
                    cmd.push_dev = 1'b1;
                    cmd.rp_adv   = 1'b1;
                    state_next   = ST_RD;
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.push_final = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/mdf_datapath.sv]
// ----------------------------------------------------------------------------
// mdf_datapath: histogram, sample store, mode search and result registers
// Histogram RAM with valid bits and write forwarding; output word register.
// ----------------------------------------------------------------------------
module mdf_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [mdf_pkg::SPEED_W-1:0] cfg_wdata,
    input  logic [mdf_pkg::SPEED_W-1:0] s_speed,
    input  mdf_pkg::mdf_cmd_t           cmd,
    output mdf_pkg::mdf_sts_t           sts,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic                        m_kind,
    output logic [mdf_pkg::SPEED_W-1:0] m_value,
    output logic [mdf_pkg::OCC_W-1:0]   m_occurrences,
    output logic                        m_overflow,
    output logic                        m_end_of_run
);
    import mdf_pkg::*;

    logic [SPEED_W-1:0] store_mem [MAX_SAMPLES];
    logic [OCC_W-1:0]   hist_mem  [SPEED_LEVELS];
    logic [SPEED_LEVELS-1:0] hv_reg;

    logic [SPEED_W-1:0] limit_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               dropped_reg;

    logic [HIST_AW-1:0] sat_idx;
    logic               has_room;
    logic               store_en;
    logic [HIST_AW-1:0] rd_addr;

    logic               ld_v_reg;
    logic [HIST_AW-1:0] ld_addr_reg;
    logic [OCC_W-1:0]   hist_q_reg;
    logic               hv_q_reg;
    logic               wr_v_reg;
    logic [HIST_AW-1:0] wr_addr_reg;
    logic [OCC_W-1:0]   wr_cnt_reg;
    logic [OCC_W-1:0]   base_cnt;
    logic [OCC_W-1:0]   new_cnt;

    logic [HIST_AW-1:0] scan_addr_reg;
    logic [HIST_AW-1:0] scan_addr_d_reg;
    logic               scan_v_reg;
    logic [OCC_W-1:0]   scan_cnt;
    logic [OCC_W-1:0]   best_reg;
    logic [HIST_AW-1:0] mode_reg;
    logic [SPEED_W-1:0] mode_val;

    logic [CNT_W-1:0]   idx_reg;
    logic [SPEED_W-1:0] st_q_reg;
    logic [SPEED_W-1:0] diff;

    logic               pend_kind_reg;
    logic [SPEED_W-1:0] pend_value_reg;
    logic [OCC_W-1:0]   pend_occ_reg;

    logic               m_valid_reg;
    logic               m_kind_reg;
    logic [SPEED_W-1:0] m_value_reg;
    logic [OCC_W-1:0]   m_occ_reg;
    logic               m_ovf_reg;
    logic               m_eor_reg;

    assign sat_idx  = sat_speed(s_speed);
    assign has_room = (count_reg < CNT_W'(MAX_SAMPLES));
    assign store_en = cmd.load && has_room;
    assign rd_addr  = cmd.scan_rd ? scan_addr_reg : sat_idx;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // set bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            ld_v_reg    <= 1'b0;
            wr_v_reg    <= 1'b0;
        end else begin
            if (cmd.push_final) begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end else if (store_en) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.load) begin
                dropped_reg <= 1'b1;
            end
            ld_v_reg <= store_en;
            wr_v_reg <= ld_v_reg;
        end
    end

    // sample store
    always_ff @(posedge aclk) begin
        if (store_en) begin
            store_mem[count_reg[SA_W-1:0]] <= SPEED_W'(sat_idx);
        end
        if (cmd.rp_rd) begin
            st_q_reg <= store_mem[idx_reg[SA_W-1:0]];
        end
    end

    // histogram read-modify-write, forward the previous write
    assign base_cnt = (wr_v_reg && (wr_addr_reg == ld_addr_reg)) ? wr_cnt_reg :
                      (hv_q_reg ? hist_q_reg : '0);
    assign new_cnt  = base_cnt + OCC_W'(1);

    always_ff @(posedge aclk) begin
        if (ld_v_reg) begin
            hist_mem[ld_addr_reg] <= new_cnt;
        end
        hist_q_reg  <= hist_mem[rd_addr];
        hv_q_reg    <= hv_reg[rd_addr];
        ld_addr_reg <= sat_idx;
        wr_addr_reg <= ld_addr_reg;
        wr_cnt_reg  <= new_cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hv_reg <= '0;
        end else if (cmd.push_final) begin
            hv_reg <= '0;
        end else if (ld_v_reg) begin
            hv_reg[ld_addr_reg] <= 1'b1;
        end
    end

    // mode search, ascending, strict compare
    assign scan_cnt = hv_q_reg ? hist_q_reg : '0;
    assign mode_val = SPEED_W'(mode_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_v_reg <= 1'b0;
        end else begin
            scan_v_reg <= cmd.scan_rd;
        end
    end

    always_ff @(posedge aclk) begin
        scan_addr_d_reg <= scan_addr_reg;
        if (cmd.scan_clr) begin
            scan_addr_reg <= '0;
            best_reg      <= '0;
            mode_reg      <= '0;
        end else begin
            if (cmd.scan_rd) begin
                scan_addr_reg <= scan_addr_reg + HIST_AW'(1);
            end
            if (scan_v_reg && (scan_cnt > best_reg)) begin
                best_reg <= scan_cnt;
                mode_reg <= scan_addr_d_reg;
            end
        end
    end

    // replay
    assign diff = (st_q_reg > mode_val) ? (st_q_reg - mode_val) : (mode_val - st_q_reg);

    always_ff @(posedge aclk) begin
        if (cmd.rp_clr) begin
            idx_reg <= '0;
        end else if (cmd.rp_adv) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    // pending word and output register
    always_ff @(posedge aclk) begin
        if (cmd.mode_load) begin
            pend_kind_reg  <= KIND_MODE;
            pend_value_reg <= mode_val;
            pend_occ_reg   <= best_reg;
        end else if (cmd.push_dev) begin
            pend_kind_reg  <= KIND_DEV;
            pend_value_reg <= st_q_reg;
            pend_occ_reg   <= '0;
        end
        if (cmd.push_dev || cmd.push_final) begin
            m_kind_reg  <= pend_kind_reg;
            m_value_reg <= pend_value_reg;
            m_occ_reg   <= pend_occ_reg;
            m_ovf_reg   <= dropped_reg;
            m_eor_reg   <= cmd.push_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push_dev || cmd.push_final) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.scan_last = (scan_addr_reg == HIST_AW'(SPEED_LEVELS - 1));
    assign sts.rp_done   = (idx_reg == count_reg);
    assign sts.dev_hit   = (diff > limit_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_value       = m_value_reg;
    assign m_occurrences = m_occ_reg;
    assign m_overflow    = m_ovf_reg;
    assign m_end_of_run  = m_eor_reg;

endmodule

[sv/mode_deviation_flagger_core.sv]
// ----------------------------------------------------------------------------
// mode_deviation_flagger_core: mode of a sample set and its outlying samples
// Input words carry one speed sample each, s_last closes the set. After the
// set, one mode word (kind 0) is sent, then every stored sample farther than
// the deviation limit from the mode (kind 1), in arrival order; the final
// word has m_end_of_run set. Samples past the store capacity are dropped and
// reported through m_overflow on every word of the set.
// Throughput: one input word per cycle while a set loads.
// After the last word: a flush, a scan of every histogram entry (one read
// port), the mode word, then a replay of each stored sample, which output
// stalls can pause, then the final word.
// s_ready is low from the last word until the final result enters the output
// register; the next set may then load while that word is still held.
// m_ready low holds the output word and pauses the replay at the next
// deviating sample. Reset clears the histogram valid bits at once, so no
// clearing pass is needed, and sets the limit to 10. cfg_we writes the
// limit; write it only while the block is idle.
// ----------------------------------------------------------------------------
module mode_deviation_flagger_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [mdf_pkg::SPEED_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [mdf_pkg::SPEED_W-1:0] s_speed,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_kind,
    output logic [mdf_pkg::SPEED_W-1:0] m_value,
    output logic [mdf_pkg::OCC_W-1:0]   m_occurrences,
    output logic                        m_overflow,
    output logic                        m_end_of_run
);
    import mdf_pkg::*;

    mdf_cmd_t cmd;
    mdf_sts_t sts;

    mdf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mdf_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_speed       (s_speed),
        .cmd           (cmd),
        .sts           (sts),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_kind        (m_kind),
        .m_value       (m_value),
        .m_occurrences (m_occurrences),
        .m_overflow    (m_overflow),
        .m_end_of_run  (m_end_of_run)
    );

endmodule
